### rtl/lbwc_pkg.sv
// Shared widths, types and constants of the D2Q5 wave collision core.
package lbwc_pkg;

  localparam int NumLanes  = 5;
  localparam int PopW      = 24;
  localparam int SpeedW    = 16;
  localparam int RateW     = 16;
  localparam int RhoW      = 27;
  localparam int JW        = 25;
  localparam int CoefW     = 19;
  localparam int EqW       = 48;
  localparam int SplitW    = 24;
  localparam int LoW       = SplitW + RateW;
  localparam int HiW       = (EqW - SplitW) + RateW + 1;
  localparam int TotW      = 64;
  localparam int QShift    = 31;
  localparam int NumStages = 7;

  typedef logic signed [PopW-1:0] pop_t;
  typedef logic signed [EqW-1:0]  eq_t;
  typedef logic [RateW-1:0]       rate_t;
  typedef logic [SpeedW-1:0]      speed_t;

  localparam pop_t  PopMax     = 24'sh7FFFFF;
  localparam pop_t  PopMin     = 24'sh800000;
  localparam rate_t RelaxReset = 16'd32768;

endpackage

### rtl/lbwc_moments.sv
// Shared front stages: density, momenta and the equilibrium terms for all lanes.
module lbwc_moments (
  input  logic               clk,
  input  logic [1:0]         en,
  input  lbwc_pkg::pop_t     pop_in  [lbwc_pkg::NumLanes],
  input  lbwc_pkg::speed_t   speed_sq,
  output lbwc_pkg::eq_t      eq_base [lbwc_pkg::NumLanes],
  output lbwc_pkg::eq_t      eq_add  [lbwc_pkg::NumLanes],
  output lbwc_pkg::pop_t     pop_out [lbwc_pkg::NumLanes]
);
  import lbwc_pkg::*;

  // First stage: exact sums.
  pop_t                    f1 [NumLanes];
  logic signed [RhoW-1:0]  rho1;
  logic signed [JW-1:0]    jx1;
  logic signed [JW-1:0]    jy1;
  speed_t                  c2_1;
  logic signed [CoefW-1:0] coef1;

  logic signed [RhoW-1:0]  rho_next;
  logic signed [CoefW-1:0] coef_next;

  // Second stage: products and signed momentum terms.
  pop_t f2 [NumLanes];
  eq_t  rest2;
  eq_t  base;
  eq_t  jxp, jxn, jyp, jyn;

  logic signed [RhoW+CoefW-1:0]  rest2_p;
  logic signed [RhoW+SpeedW:0]   base_p;
  eq_t                           jx16, jy16;

  always_comb begin
    rho_next = RhoW'(pop_in[0]) + RhoW'(pop_in[1]) + RhoW'(pop_in[2])
             + RhoW'(pop_in[3]) + RhoW'(pop_in[4]);
    // 2 * (1 - 2*c2) in Q.16, so that rest2 lands in units of 2^-17.
    coef_next = 19'sd131072 - $signed({1'b0, speed_sq, 2'b00});
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      f1    <= pop_in;
      rho1  <= rho_next;
      jx1   <= JW'(pop_in[1]) - JW'(pop_in[3]);
      jy1   <= JW'(pop_in[2]) - JW'(pop_in[4]);
      c2_1  <= speed_sq;
      coef1 <= coef_next;
    end
  end

  always_comb begin
    rest2_p = rho1 * coef1;
    base_p  = rho1 * $signed({1'b0, c2_1});
    jx16    = EqW'($signed({jx1, 16'd0}));
    jy16    = EqW'($signed({jy1, 16'd0}));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      f2    <= f1;
      rest2 <= EqW'(rest2_p);
      base  <= EqW'(base_p);
      jxp   <= jx16;
      jxn   <= -jx16;
      jyp   <= jy16;
      jyn   <= -jy16;
    end
  end

  assign pop_out = f2;

  assign eq_base[0] = rest2;
  assign eq_add[0]  = '0;
  assign eq_base[1] = base;
  assign eq_add[1]  = jxp;
  assign eq_base[2] = base;
  assign eq_add[2]  = jyp;
  assign eq_base[3] = base;
  assign eq_add[3]  = jxn;
  assign eq_base[4] = base;
  assign eq_add[4]  = jyn;

endmodule

### rtl/lbwc_lane.sv
// One relaxation lane: difference, split multiply by the rate, rounding and saturation.
module lbwc_lane (
  input  logic            clk,
  input  logic [3:0]      en,
  input  lbwc_pkg::eq_t   eq_base,
  input  lbwc_pkg::eq_t   eq_add,
  input  lbwc_pkg::pop_t  pop,
  input  lbwc_pkg::rate_t rate,
  output lbwc_pkg::pop_t  new_pop,
  output logic            sat
);
  import lbwc_pkg::*;

  eq_t                    diff;
  pop_t                   f_a, f_b;
  logic [LoW-1:0]         lo;
  logic signed [HiW-1:0]  hi;
  logic signed [TotW-1:0] total;

  logic signed [TotW-1:0] total_next;
  logic                   in_range;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      diff <= eq_base + eq_add - EqW'($signed({pop, 17'd0}));
      f_a  <= pop;
    end
  end

  // The difference is split in two halves so each product stays near 24 by 17 bits.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      lo  <= diff[SplitW-1:0] * rate;
      hi  <= $signed(diff[EqW-1:SplitW]) * $signed({1'b0, rate});
      f_b <= f_a;
    end
  end

  // f << 31 plus the rounding half; its low bits are zero so the half is just a set bit.
  always_comb begin
    total_next = $signed({hi[TotW-SplitW-1:0], {SplitW{1'b0}}})
               + $signed({{(TotW-LoW){1'b0}}, lo})
               + $signed({{(TotW-PopW-QShift){f_b[PopW-1]}}, f_b, 1'b1, {(QShift-1){1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      total <= total_next;
    end
  end

  // The shifted value fits when every bit above the result's sign bit matches it.
  assign in_range = (&total[TotW-1:QShift+PopW-1]) || !(|total[TotW-1:QShift+PopW-1]);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (in_range) begin
        new_pop <= total[QShift+PopW-1:QShift];
      end else begin
        new_pop <= total[TotW-1] ? PopMin : PopMax;
      end
      sat <= !in_range;
    end
  end

endmodule

### rtl/lattice_boltzmann_wave_collision_core.sv
// Top level of the D2Q5 wave collision core: stream ports, register, lanes and output merge.
// Takes one cell per clock while the output accepts, and returns its five relaxed populations;
// the depth is set by the shared moment stages, four lane stages (difference, split rate
// multiply, rounding sum, saturation) and the output register. Every stage can hold its item
// while the output is stalled, so the core keeps taking cells until all seven stages are full.
// relax_rate is written through the cfg channel, which is always ready; write it only while no
// cell is in flight.
module lattice_boltzmann_wave_collision_core (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // pop_rest, pop_east, pop_north, pop_west, pop_south, speed_sq
  input  logic [135:0]              s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // new_rest, new_east, new_north, new_west, new_south
  output logic [119:0]              m_tdata,
  // saturated
  output logic                      m_tuser,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  lbwc_pkg::rate_t           cfg_data
);
  import lbwc_pkg::*;

  rate_t                relax_rate;
  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] vld_next;
  logic [NumStages-1:0] en;

  pop_t   pop_in  [NumLanes];
  pop_t   pop_mid [NumLanes];
  pop_t   new_pop [NumLanes];
  eq_t    eq_base [NumLanes];
  eq_t    eq_add  [NumLanes];
  logic   lane_sat [NumLanes];
  speed_t speed_sq;

  // A stage loads when it is empty or its successor loads in the same cycle.
  always_comb begin
    en[NumStages-1] = !vld[NumStages-1] || m_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
    for (int k = 0; k < NumStages; k++) begin
      if (k == 0) begin
        vld_next[k] = en[k] ? s_tvalid : vld[k];
      end else begin
        vld_next[k] = en[k] ? vld[k-1] : vld[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld        <= '0;
      relax_rate <= RelaxReset;
    end else begin
      vld <= vld_next;
      if (cfg_valid) begin
        relax_rate <= cfg_data;
      end
    end
  end

  assign cfg_ready = 1'b1;
  assign s_tready  = en[0];

  always_comb begin
    for (int i = 0; i < NumLanes; i++) begin
      pop_in[i] = s_tdata[i*PopW +: PopW];
    end
    speed_sq = s_tdata[NumLanes*PopW +: SpeedW];
  end

  lbwc_moments u_moments (
    .clk      (clk),
    .en       (en[1:0]),
    .pop_in   (pop_in),
    .speed_sq (speed_sq),
    .eq_base  (eq_base),
    .eq_add   (eq_add),
    .pop_out  (pop_mid)
  );

  for (genvar g = 0; g < NumLanes; g++) begin : g_lane
    lbwc_lane u_lane (
      .clk     (clk),
      .en      (en[5:2]),
      .eq_base (eq_base[g]),
      .eq_add  (eq_add[g]),
      .pop     (pop_mid[g]),
      .rate    (relax_rate),
      .new_pop (new_pop[g]),
      .sat     (lane_sat[g])
    );
  end

  // Merge: pack the lanes and combine their clip flags.
  always_ff @(posedge clk) begin
    if (en[NumStages-1]) begin
      for (int i = 0; i < NumLanes; i++) begin
        m_tdata[i*PopW +: PopW] <= new_pop[i];
      end
      m_tuser <= lane_sat[0] || lane_sat[1] || lane_sat[2] || lane_sat[3] || lane_sat[4];
    end
  end

  assign m_tvalid = vld[NumStages-1];

  a_cfg_write: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |=> relax_rate == $past(cfg_data))
    else $error("relax_rate did not take the written value");

  a_ready_not_full: assert property (@(posedge clk) disable iff (rst)
    !(&vld) |-> s_tready)
    else $error("input stalled while the pipeline has a free stage");

  a_reset_rate: assert property (@(posedge clk)
    $past(rst) |-> relax_rate == RelaxReset)
    else $error("relax_rate not at its reset value after reset");

endmodule
